// File: rtl/wpm_pkg.sv
// Package for the wildcard pattern matcher.
// Holds sizes, character codes and register indexes shared by the interfaces and the core.
// No dependencies.
package wpm_pkg;

	localparam int PATTERN_CHARS = 16;
	localparam int POS_W = PATTERN_CHARS + 1;
	localparam int CHAR_W = 8;
	localparam int LEN_W = 5;
	localparam int WORD_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_ANY = 8'h3F;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [PATTERN_CHARS-1:0] pmask_t;

endpackage

// File: rtl/wpm_if.sv
// Channel interfaces of the wildcard pattern matcher: characters in, match results out,
// and configuration writes. Depends on wpm_pkg.
interface wpm_char_if;
	logic valid;
	logic ready;
	wpm_pkg::char_t char_code;
	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

interface wpm_match_if;
	logic valid;
	logic ready;
	logic matched;
	modport source(output valid, output matched, input ready);
	modport sink(input valid, input matched, output ready);
endinterface

interface wpm_cfg_if;
	logic valid;
	logic ready;
	logic [wpm_pkg::CFG_IDX_W-1:0] index;
	logic [wpm_pkg::WORD_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/wildcard_pattern_matcher_core.sv
// Top level of the wildcard pattern matcher: configuration registers, input register,
// active-position update and result register. Depends on wpm_pkg and the interfaces in wpm_if.sv.
//
// The block matches a candidate string, one character per transaction, against a pattern of up
// to 16 characters in which '*' matches any run and '?' exactly one character. A zero character
// ends the candidate and produces one transaction on the result channel; the block then rearms.
// It takes one character every cycle while no zero character is held: a character enters an input
// register, from there the active-position vector is updated and, for a zero character, the match
// bit is loaded into the result register, which offers the result. A waiting result stalls only
// a following zero character. Configuration writes are always accepted, and those to the pattern
// registers rearm the matcher; they are meant for times when no candidate is in flight.
module wildcard_pattern_matcher_core (
	input logic clk,
	input logic arst_n,
	wpm_cfg_if.sink cfg,
	wpm_char_if.sink char_in,
	wpm_match_if.source res
);

	logic [wpm_pkg::WORD_W-1:0] pat_low_q;
	logic [wpm_pkg::WORD_W-1:0] pat_high_q;
	logic [wpm_pkg::LEN_W-1:0] pat_len_q;

	// Positions are kept before star closure, so a new pattern needs no recomputed rearm vector.
	wpm_pkg::pos_t raw_q;

	logic valid_s1;
	wpm_pkg::char_t char_s1;
	logic out_valid_q;
	logic matched_q;

	logic [2*wpm_pkg::WORD_W-1:0] pat_bits;
	logic [wpm_pkg::LEN_W-1:0] len_sat;
	wpm_pkg::pmask_t live;
	wpm_pkg::pmask_t star_en;
	wpm_pkg::pmask_t adv_en;
	wpm_pkg::pos_t end_oh;
	wpm_pkg::pos_t active;
	wpm_pkg::pos_t next_raw;
	logic is_end;
	logic s1_go;

	function automatic wpm_pkg::pos_t star_close(wpm_pkg::pos_t v, wpm_pkg::pmask_t stars);
		wpm_pkg::pos_t r;
		r = v;
		for (int i = 0; i < wpm_pkg::PATTERN_CHARS; i++) begin
			r[i+1] = r[i+1] | (r[i] & stars[i]);
		end
		return r;
	endfunction

	assign pat_bits = {pat_high_q, pat_low_q};
	assign len_sat = (pat_len_q > wpm_pkg::LEN_W'(wpm_pkg::PATTERN_CHARS)) ?
		wpm_pkg::LEN_W'(wpm_pkg::PATTERN_CHARS) : pat_len_q;

	// A position is live when it lies within the length and neither it nor an earlier position holds a zero character.
	always_comb begin
		logic run;
		wpm_pkg::char_t pc;
		run = 1'b1;
		for (int i = 0; i < wpm_pkg::PATTERN_CHARS; i++) begin
			pc = pat_bits[8*i +: 8];
			run = run & (wpm_pkg::LEN_W'(i) < len_sat) & (pc != wpm_pkg::CH_NUL);
			live[i] = run;
			star_en[i] = run & (pc == wpm_pkg::CH_STAR);
			adv_en[i] = run & ((pc == wpm_pkg::CH_ANY) || (pc == char_s1));
		end
		end_oh[0] = ~live[0];
		for (int i = 1; i < wpm_pkg::PATTERN_CHARS; i++) begin
			end_oh[i] = live[i-1] & ~live[i];
		end
		end_oh[wpm_pkg::PATTERN_CHARS] = live[wpm_pkg::PATTERN_CHARS-1];
	end

	always_comb begin
		active = star_close(raw_q, star_en);
		next_raw = '0;
		for (int i = 0; i < wpm_pkg::PATTERN_CHARS; i++) begin
			next_raw[i] = next_raw[i] | (active[i] & star_en[i]);
			next_raw[i+1] = active[i] & adv_en[i] & ~star_en[i];
		end
	end

	assign is_end = (char_s1 == wpm_pkg::CH_NUL);
	assign s1_go = valid_s1 & (~is_end | ~out_valid_q | res.ready);

	assign char_in.ready = ~valid_s1 | s1_go;
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.matched = matched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q <= '0;
			pat_high_q <= '0;
			pat_len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				wpm_pkg::REG_PAT_LOW: pat_low_q <= cfg.data;
				wpm_pkg::REG_PAT_HIGH: pat_high_q <= cfg.data;
				wpm_pkg::REG_PAT_LEN: pat_len_q <= cfg.data[wpm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= wpm_pkg::POS_W'(1);
		end else if (cfg.valid && cfg.ready &&
			(cfg.index == wpm_pkg::REG_PAT_LOW || cfg.index == wpm_pkg::REG_PAT_HIGH ||
			cfg.index == wpm_pkg::REG_PAT_LEN)) begin
			raw_q <= wpm_pkg::POS_W'(1);
		end else if (s1_go) begin
			raw_q <= is_end ? wpm_pkg::POS_W'(1) : next_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && is_end) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_end) begin
			matched_q <= |(active & end_oh);
		end
	end

`ifndef ASSERT_OFF
	// A waiting result must never be overwritten by the next end of candidate.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready && s1_go) |-> !is_end)
		else $error("pending result overwritten");

	// Finishing a candidate rearms the matcher at the start position.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_end) |=> (raw_q == wpm_pkg::POS_W'(1)))
		else $error("matcher not rearmed after end of candidate");

	// An end of candidate that leaves stage one always shows up as a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_end) |=> out_valid_q)
		else $error("end of candidate produced no result");
`endif

endmodule

// File: sim/wildcard_pattern_matcher_core_test.sv
// Self-checking testbench for wildcard_pattern_matcher_core: drives candidate strings and
// pattern register writes, predicts each match bit and compares it with the result channel.
// Depends on wpm_pkg and the interfaces in wpm_if.sv.
module wildcard_pattern_matcher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [wpm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1750;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	// Candidate and pattern text is drawn mostly from a small alphabet so that matches happen.
	localparam wpm_pkg::char_t ALPHABET [5] =
		'{8'h61, 8'h62, 8'h63, wpm_pkg::CH_STAR, wpm_pkg::CH_ANY};

	logic clk = 1'b0;
	logic arst_n;

	wpm_cfg_if cfg_ch();
	wpm_char_if char_ch();
	wpm_match_if match_ch();

	wildcard_pattern_matcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.char_in(char_ch),
		.res(match_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Our own view of the pattern registers and of the active-position vector.
	logic [wpm_pkg::WORD_W-1:0] pat_word_lo = '0;
	logic [wpm_pkg::WORD_W-1:0] pat_word_hi = '0;
	logic [wpm_pkg::LEN_W-1:0] pat_len_reg = '0;
	wpm_pkg::pos_t live_pos;

	wpm_pkg::char_t char_q[$];
	logic match_q[$];
	int unsigned chars_pushed = 0;
	int unsigned chars_taken = 0;
	int unsigned cands_done = 0;
	int unsigned cands_hit = 0;
	int unsigned reg_writes = 0;
	int unsigned fails = 0;
	int unsigned hold_req = 0;
	int unsigned hold_ack;
	int unsigned hold_left;
	int unsigned idle_cycles = 0;
	bit calm = 1'b0;

	function automatic wpm_pkg::char_t pattern_char(int unsigned i);
		if (i < 8)
			return pat_word_lo[8*i +: 8];
		if (i < 16)
			return pat_word_hi[8*(i-8) +: 8];
		return wpm_pkg::CH_NUL;
	endfunction

	// Length in use: saturated, and cut at the first zero character.
	function automatic int unsigned pattern_span();
		int unsigned n;
		n = (pat_len_reg > wpm_pkg::PATTERN_CHARS) ? wpm_pkg::PATTERN_CHARS : pat_len_reg;
		for (int unsigned i = 0; i < n; i++)
			if (pattern_char(i) == wpm_pkg::CH_NUL)
				return i;
		return n;
	endfunction

	function automatic wpm_pkg::pos_t close_stars(wpm_pkg::pos_t v);
		int unsigned span;
		span = pattern_span();
		for (int unsigned i = 0; i < span; i++)
			if (v[i] && pattern_char(i) == wpm_pkg::CH_STAR)
				v[i+1] = 1'b1;
		return v;
	endfunction

	function automatic void rearm_matcher();
		live_pos = close_stars(wpm_pkg::pos_t'(1));
	endfunction

	function automatic void advance_matcher(wpm_pkg::char_t c);
		wpm_pkg::pos_t nxt;
		int unsigned span;
		wpm_pkg::char_t pc;
		span = pattern_span();
		if (c == wpm_pkg::CH_NUL) begin
			match_q.push_back(live_pos[span]);
			cands_done++;
			if (live_pos[span])
				cands_hit++;
			rearm_matcher();
			return;
		end
		nxt = '0;
		for (int unsigned i = 0; i < span; i++) begin
			if (live_pos[i]) begin
				pc = pattern_char(i);
				if (pc == wpm_pkg::CH_STAR)
					nxt[i] = 1'b1;
				else if (pc == wpm_pkg::CH_ANY || pc == c)
					nxt[i+1] = 1'b1;
			end
		end
		live_pos = close_stars(nxt);
	endfunction

	function automatic void apply_reg(logic [wpm_pkg::CFG_IDX_W-1:0] idx,
			logic [wpm_pkg::WORD_W-1:0] value);
		case (idx)
			wpm_pkg::REG_PAT_LOW: pat_word_lo = value;
			wpm_pkg::REG_PAT_HIGH: pat_word_hi = value;
			wpm_pkg::REG_PAT_LEN: pat_len_reg = value[wpm_pkg::LEN_W-1:0];
			default: return;
		endcase
		rearm_matcher();
	endfunction

	function automatic wpm_pkg::char_t filler_char();
		if ($urandom_range(99) < 60)
			return ALPHABET[$urandom_range(4)];
		return wpm_pkg::char_t'($urandom_range(255, 1));
	endfunction

	function automatic wpm_pkg::char_t pattern_symbol();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 85)
			return ALPHABET[$urandom_range(4)];
		if (r < 95)
			return wpm_pkg::char_t'($urandom_range(255, 1));
		return wpm_pkg::CH_NUL;
	endfunction

	// Character driver: one transaction per accepted character, prediction on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_ch.valid <= 1'b0;
			char_ch.char_code <= wpm_pkg::CH_NUL;
		end else begin
			if (char_ch.valid && char_ch.ready) begin
				advance_matcher(char_ch.char_code);
				chars_taken++;
			end
			if (!char_ch.valid || char_ch.ready) begin
				if (char_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
					char_ch.valid <= 1'b1;
					char_ch.char_code <= char_q.pop_front();
				end else
					char_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor, with a long hold-off whenever the sequencer asks for one.
	always @(posedge clk or negedge arst_n) begin : monitor
		logic want;
		if (!arst_n) begin
			match_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_ack <= 0;
		end else begin
			if (match_ch.valid && match_ch.ready) begin
				if (match_q.size() == 0) begin
					$error("matched: no result expected, got %0b", match_ch.matched);
					fails++;
				end else begin
					want = match_q.pop_front();
					if (match_ch.matched !== want) begin
						$error("matched: expected %0b, got %0b", want, match_ch.matched);
						fails++;
					end
				end
			end
			if (hold_left != 0) begin
				match_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				match_ch.ready <= 1'b0;
			end else
				match_ch.ready <= calm || $urandom_range(99) >= 9;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_ch.valid && char_ch.ready) || (match_ch.valid && match_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("wildcard_pattern_matcher_core_test NOT OK");
				$finish;
			end
		end
	end

	task automatic push_char(wpm_pkg::char_t c);
		char_q.push_back(c);
		chars_pushed++;
	endtask

	// Waits until every character has gone in and every result has come out.
	task automatic drain();
		while (chars_taken != chars_pushed || match_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high; the caller lowers it after its last write.
	task automatic write_reg(logic [wpm_pkg::CFG_IDX_W-1:0] idx,
			logic [wpm_pkg::WORD_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, value);
		reg_writes++;
	endtask

	task automatic program_pattern(int unsigned phase);
		wpm_pkg::char_t pat [wpm_pkg::PATTERN_CHARS];
		logic [wpm_pkg::WORD_W-1:0] lo, hi, len_word;
		int unsigned style, len, r;
		bit wrote;
		style = (phase < 2) ? phase : (($urandom_range(9) == 0) ? $urandom_range(1) : 2);
		case (style)
			0: begin
				foreach (pat[i]) pat[i] = 8'hFF;
				len_word = wpm_pkg::PATTERN_CHARS;
			end
			1: begin
				foreach (pat[i]) pat[i] = wpm_pkg::CH_NUL;
				len_word = '1;
			end
			default: begin
				len = $urandom_range(wpm_pkg::PATTERN_CHARS);
				foreach (pat[i])
					pat[i] = (i < len) ? pattern_symbol() : wpm_pkg::char_t'($urandom_range(255));
				r = $urandom_range(9);
				if (r < 8)
					len_word = len;
				else if (r == 8)
					len_word = $urandom_range(31);
				else
					len_word = {$urandom, $urandom};
			end
		endcase
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat[i];
			hi[8*i +: 8] = pat[i+8];
		end
		wrote = 1'b0;
		if (phase < 2 || $urandom_range(9) < 7) begin
			write_reg(wpm_pkg::REG_PAT_LOW, lo);
			wrote = 1'b1;
		end
		if (phase < 2 || $urandom_range(9) < 7) begin
			write_reg(wpm_pkg::REG_PAT_HIGH, hi);
			wrote = 1'b1;
		end
		if (phase < 2 || !wrote || $urandom_range(9) < 7)
			write_reg(wpm_pkg::REG_PAT_LEN, len_word);
		if ($urandom_range(9) == 0)
			write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly strings built to follow the pattern, some of them damaged, the rest noise.
	task automatic send_candidate(bit short_only, bit finish);
		wpm_pkg::char_t cand[$];
		int unsigned kind, span, at;
		wpm_pkg::char_t pc;
		span = pattern_span();
		kind = short_only ? 99 : $urandom_range(99);
		if (kind < 85) begin
			for (int unsigned i = 0; i < span; i++) begin
				pc = pattern_char(i);
				if (pc == wpm_pkg::CH_STAR)
					repeat ($urandom_range(3)) cand.push_back(filler_char());
				else if (pc == wpm_pkg::CH_ANY)
					cand.push_back(filler_char());
				else
					cand.push_back(pc);
			end
			if (kind >= 60) begin
				at = $urandom_range(cand.size());
				case ($urandom_range(2))
					0: cand.insert(at, filler_char());
					1: if (at < cand.size()) cand.delete(at);
					default: if (at < cand.size()) cand[at] = filler_char();
				endcase
			end
		end else
			repeat ($urandom_range(short_only ? 2 : 10)) cand.push_back(filler_char());
		foreach (cand[k]) push_char(cand[k]);
		if (finish)
			push_char(wpm_pkg::CH_NUL);
	endtask

	initial begin : sequencer
		int unsigned random_start, phase, n;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= wpm_pkg::REG_PAT_LOW;
		cfg_ch.data <= '0;
		rearm_matcher();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern after reset: only the empty candidate matches.
		push_char(wpm_pkg::CH_NUL);
		push_char(8'h41);
		push_char(wpm_pkg::CH_NUL);
		drain();

		// A lone star matches the empty candidate and any other string.
		write_reg(wpm_pkg::REG_PAT_LOW, 64'h2A);
		write_reg(wpm_pkg::REG_PAT_LEN, 64'd1);
		cfg_ch.valid <= 1'b0;
		push_char(wpm_pkg::CH_NUL);
		push_char(8'hFF);
		push_char(8'h01);
		push_char(wpm_pkg::CH_NUL);
		drain();

		// Pattern "a?c": the length saturates and the zero after 'c' ends the pattern.
		// The '?' must not match past the end of "ac".
		write_reg(wpm_pkg::REG_PAT_LOW, 64'h0000_0000_0063_3F61);
		write_reg(wpm_pkg::REG_PAT_LEN, '1);
		cfg_ch.valid <= 1'b0;
		push_char(8'h61);
		push_char(8'h62);
		push_char(8'h63);
		push_char(wpm_pkg::CH_NUL);
		push_char(8'h61);
		push_char(8'h63);
		push_char(wpm_pkg::CH_NUL);
		push_char(8'h61);
		drain();

		// The write rearms, so the stray 'a' above is dropped and "abc" matches.
		write_reg(wpm_pkg::REG_PAT_HIGH, '1);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
		push_char(8'h61);
		push_char(8'h62);
		push_char(8'h63);
		push_char(wpm_pkg::CH_NUL);
		drain();

		random_start = chars_pushed;
		phase = 0;
		// The calm phase and the long receiver hold-off always run.
		while (chars_pushed - random_start < RANDOM_ITEMS || phase <= 5) begin
			program_pattern(phase);
			if (phase == 3)
				calm = 1'b1;
			if (phase == 5)
				hold_req++;
			n = (phase == 5) ? 60 : (phase == 3) ? 40 : $urandom_range(30, 8);
			repeat (n) send_candidate(phase == 5, 1'b1);
			// Sometimes leave a candidate unfinished for the next write to discard.
			if ($urandom_range(99) < 20)
				send_candidate(1'b0, 1'b0);
			drain();
			calm = 1'b0;
			phase++;
		end

		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d candidates, %0d of them matching, in %0d characters,",
			cands_done, cands_hit, chars_taken);
		$display("with %0d register writes over %0d pattern settings.", reg_writes, phase + 4);
		if (fails == 0)
			$display("wildcard_pattern_matcher_core_test OK");
		else
			$display("wildcard_pattern_matcher_core_test NOT OK");
		$finish;
	end

endmodule
